/* rtl/core/assert_macros.svh */
// Assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swra assertion failed");

// next-cycle implication
`define SWRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swra assertion failed");

`endif

/* rtl/core/swra_pkg.sv */
package swra_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned CREDIT_MAX     = 64;
  localparam logic [6:0]  WINDOW_RST     = 7'd16;
  localparam int unsigned CFG_ADDR_W     = 3;

  // register index (word address)
  localparam logic REG_RX_WIN = 1'b0;

  // item and result kinds
  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_DRAIN   = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] seq_number;
    logic        fin_flag;
    logic        dropped;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] ack_number;
    logic [6:0]  window_credit;
    logic        final_ack;
    logic        duplicate_ack;
    logic        out_of_window;
    logic        unlock_sent;
    logic [6:0]  consumed_count;
    logic        consumer_done;
  } out_result_t;

  typedef struct packed {
    logic fin;
    logic rcvd;
  } ring_entry_t;

endpackage

/* rtl/core/swra_ring.sv */
module swra_ring #(
  parameter int unsigned DEPTH = swra_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  swra_pkg::ring_entry_t wr_data,
  input  logic [AW-1:0]         rd_addr,
  output swra_pkg::ring_entry_t rd_data
);
  import swra_pkg::*;

  ring_entry_t mem_r [DEPTH];
  ring_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/sliding_window_receiver_ack_top.sv */
// Channel | Signals                                   | Handshake
// input   | in_item                                   | start & !busy
// result  | out_result                                | out_valid, one cycle
// config  | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// Dropped arrival: taken, no result. Out-of-range arrival: result in the cycle after
// the beat. Held or no-credit arrival: slot read, checked in S_ACHK, then result.
// Accepted arrival: slot marked in S_ACHK, S_WSTART, then S_WCK advances the ack, one
// ring read per segment, until a gap or the far end of the ring. Drain: S_DCK consumes
// one entry per step, then reports. After reset the ring is cleared, one entry a cycle.
// The result sink cannot stall; busy is the only back-pressure.
module sliding_window_receiver_ack_top #(
  parameter int unsigned RING_DEPTH = swra_pkg::RING_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  swra_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  output swra_pkg::out_result_t                 out_result,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [swra_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import swra_pkg::*;

  localparam int unsigned IW      = $clog2(RING_DEPTH);
  localparam int unsigned WIN_MAX = (RING_DEPTH < CREDIT_MAX) ? RING_DEPTH : CREDIT_MAX;
  localparam logic [15:0]   DEPTH16 = 16'(RING_DEPTH);
  localparam logic [IW:0]   DEPTH_W = (IW+1)'(RING_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(RING_DEPTH - 1);
  localparam logic [6:0]    CREDIT_TOP = 7'(CREDIT_MAX);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_ACHK, S_WSTART, S_WCK, S_DCK
  } state_t;

  function automatic logic [6:0] clamp_win(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (r == 7'd0) r = 7'd1;
    if (r > 7'(WIN_MAX)) r = 7'(WIN_MAX);
    return r;
  endfunction

  state_t      state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  in_item_t    in_r, in_nxt;
  logic [IW-1:0] sl_r, sl_nxt;
  logic [IW-1:0] ws_r, ws_nxt;
  logic [IW:0]   wo_r, wo_nxt;
  logic [15:0] ne_r, ne_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [6:0]  credit_r, credit_nxt;
  logic        locked_r, locked_nxt;
  logic        fs_r, fs_nxt;
  logic [15:0] end_r, end_nxt;
  logic        dup_r, dup_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  win_r, win_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_result_t out_r, out_nxt;

  // shared slot adder and distance unit
  logic [IW-1:0] su_base, su_off, slot;
  logic [IW:0]   su_sum;
  logic [15:0]   seq_gap;
  logic          in_range;
  logic [IW:0]   wo_inc;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ring_entry_t   wr_data, rd_data;

  logic        emit, em_kind, em_dup, em_oow, em_unlock, em_done;
  logic [6:0]  em_cnt;
  logic        cfg_wr;

  assign seq_gap  = ((state_r == S_IDLE) ? in_item.seq_number : ne_r) - cp_r;
  assign in_range = seq_gap < DEPTH16;
  assign su_sum   = {1'b0, su_base} + {1'b0, su_off};
  assign slot     = (su_sum >= DEPTH_W) ? IW'(su_sum - DEPTH_W) : su_sum[IW-1:0];
  assign wo_inc   = wo_r + 1'b1;

  always_comb begin
    case (state_r)
      S_IDLE: begin
        su_base = head_r;
        su_off  = (in_item.action == ACT_DRAIN) ? '0 : seq_gap[IW-1:0];
      end
      S_WSTART: begin
        su_base = head_r;
        su_off  = seq_gap[IW-1:0];
      end
      S_WCK: begin
        su_base = ws_r;
        su_off  = IW'(1);
      end
      S_DCK: begin
        su_base = head_r;
        su_off  = IW'(1);
      end
      default: begin
        su_base = head_r;
        su_off  = '0;
      end
    endcase
  end

  swra_ring #(.DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    in_nxt        = in_r;
    sl_nxt        = sl_r;
    ws_nxt        = ws_r;
    wo_nxt        = wo_r;
    ne_nxt        = ne_r;
    cp_nxt        = cp_r;
    head_nxt      = head_r;
    credit_nxt    = credit_r;
    locked_nxt    = locked_r;
    fs_nxt        = fs_r;
    end_nxt       = end_r;
    dup_nxt       = dup_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    win_nxt       = win_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    emit          = 1'b0;
    em_kind       = ACT_ARRIVAL;
    em_dup        = 1'b0;
    em_oow        = 1'b0;
    em_unlock     = 1'b0;
    em_cnt        = 7'd0;
    em_done       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = '0;

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt = in_item;
          if (in_item.action == ACT_DRAIN) begin
            cnt_nxt   = 7'd0;
            done_nxt  = 1'b0;
            state_nxt = S_DCK;
          end else if (!in_item.dropped) begin
            if (!in_range) begin
              emit   = 1'b1;
              em_oow = 1'b1;
            end else begin
              sl_nxt    = slot;
              state_nxt = S_ACHK;
            end
          end
        end
      end
      S_ACHK: begin
        if (rd_data.rcvd) begin
          emit      = 1'b1;
          em_dup    = 1'b1;
          state_nxt = S_IDLE;
        end else if (credit_r == 7'd0) begin
          emit      = 1'b1;
          em_oow    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = sl_r;
          wr_data.rcvd = 1'b1;
          wr_data.fin  = in_r.fin_flag;
          credit_nxt   = credit_r - 1'b1;
          if (credit_r == 7'd1) locked_nxt = 1'b1;
          if (in_r.fin_flag) begin
            fs_nxt  = 1'b1;
            end_nxt = in_r.seq_number + 1'b1;
          end
          dup_nxt   = in_r.seq_number != ne_r;
          state_nxt = S_WSTART;
        end
      end
      S_WSTART: begin
        if (in_range) begin
          ws_nxt    = slot;
          wo_nxt    = {1'b0, seq_gap[IW-1:0]};
          state_nxt = S_WCK;
        end else begin
          emit      = 1'b1;
          em_dup    = dup_r;
          state_nxt = S_IDLE;
        end
      end
      S_WCK: begin
        if (rd_data.rcvd) begin
          ne_nxt = ne_r + 1'b1;
          ws_nxt = slot;
          wo_nxt = wo_inc;
          if (wo_inc >= DEPTH_W) begin
            emit      = 1'b1;
            em_dup    = dup_r;
            state_nxt = S_IDLE;
          end
        end else begin
          emit      = 1'b1;
          em_dup    = dup_r;
          state_nxt = S_IDLE;
        end
      end
      S_DCK: begin
        if (cp_r != ne_r && !cnt_r[6] && rd_data.rcvd) begin
          wr_en    = 1'b1;
          wr_addr  = head_r;
          done_nxt = done_r | rd_data.fin;
          head_nxt = slot;
          cp_nxt   = cp_r + 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (credit_r < CREDIT_TOP) credit_nxt = credit_r + 1'b1;
        end else begin
          emit    = 1'b1;
          em_kind = ACT_DRAIN;
          em_cnt  = cnt_r;
          em_done = done_r;
          if (locked_r && credit_r != 7'd0) begin
            locked_nxt = 1'b0;
            em_unlock  = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_nxt.result_kind    = em_kind;
      out_nxt.ack_number     = ne_nxt;
      out_nxt.window_credit  = credit_nxt;
      out_nxt.final_ack      = fs_nxt && (ne_nxt == end_nxt);
      out_nxt.duplicate_ack  = em_dup;
      out_nxt.out_of_window  = em_oow;
      out_nxt.unlock_sent    = em_unlock;
      out_nxt.consumed_count = em_cnt;
      out_nxt.consumer_done  = em_done;
    end

    if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_RX_WIN) begin
      win_nxt    = pwdata[6:0];
      credit_nxt = clamp_win(pwdata[6:0]);
      locked_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      in_r        <= '0;
      sl_r        <= '0;
      ws_r        <= '0;
      wo_r        <= '0;
      ne_r        <= '0;
      cp_r        <= '0;
      head_r      <= '0;
      credit_r    <= clamp_win(WINDOW_RST);
      locked_r    <= 1'b0;
      fs_r        <= 1'b0;
      end_r       <= '0;
      dup_r       <= 1'b0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      win_r       <= WINDOW_RST;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      in_r        <= in_nxt;
      sl_r        <= sl_nxt;
      ws_r        <= ws_nxt;
      wo_r        <= wo_nxt;
      ne_r        <= ne_nxt;
      cp_r        <= cp_nxt;
      head_r      <= head_nxt;
      credit_r    <= credit_nxt;
      locked_r    <= locked_nxt;
      fs_r        <= fs_nxt;
      end_r       <= end_nxt;
      dup_r       <= dup_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign pready     = 1'b1;
  assign prdata     = (paddr[CFG_ADDR_W-1:2] == REG_RX_WIN) ? {25'd0, win_r} : 32'd0;

endmodule

/* rtl/core/swra_checker.sv */
`include "assert_macros.svh"

module swra_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input swra_pkg::in_item_t    in_item,
  input logic                  out_valid,
  input swra_pkg::out_result_t out_result
);
  import swra_pkg::*;

  // a dropped arrival yields no result beat
  `SWRA_ASSERT_NEXT(a_drop_silent, start && !busy && in_item.action == ACT_ARRIVAL && in_item.dropped, !out_valid)

  // drain reports never carry arrival flags
  `SWRA_ASSERT_NOW(a_drain_flags, out_valid && out_result.result_kind == ACT_DRAIN, !out_result.duplicate_ack && !out_result.out_of_window)

  // arrival acks never carry drain fields
  `SWRA_ASSERT_NOW(a_arrival_fields, out_valid && out_result.result_kind == ACT_ARRIVAL, !out_result.unlock_sent && out_result.consumed_count == 7'd0 && !out_result.consumer_done)

  // credit and consumed count stay within the ceiling
  `SWRA_ASSERT_NOW(a_credit_cap, out_valid, out_result.window_credit <= 7'(CREDIT_MAX) && out_result.consumed_count <= 7'(CREDIT_MAX))

endmodule

bind sliding_window_receiver_ack_top swra_checker u_swra_checker (.*);
